### hdl/ldeq_pkg.sv
// Shared types and constants for the linear double-ended queue core.
`default_nettype none
package ldeq_pkg;

    localparam int DEPTH  = 8;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_POP_FRONT  = 2'd1,
        REQ_PUSH_REAR  = 2'd2,
        REQ_POP_REAR   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef struct packed {
        logic load;   // capture the request item
        logic exec;   // update indices, touch the slot store
    } t_ctrl_cmd;

endpackage
`default_nettype wire

### hdl/ldeq_ctrl.sv
// Request sequencer: accept, execute, then strobe the result for one cycle.
`default_nettype none
module ldeq_ctrl
    import ldeq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    output logic      o_valid,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start) n_state = S_EXEC;
            S_EXEC: n_state = S_RESP;
            S_RESP: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = (r_state == S_RESP);
    assign o_cmd.load = (r_state == S_IDLE) && start;
    assign o_cmd.exec = (r_state == S_EXEC);

endmodule
`default_nettype wire

### hdl/ldeq_dp.sv
// Deque datapath: top/bottom indices, empty flag, slot store and result registers.
`default_nettype none
module ldeq_dp
    import ldeq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctrl_cmd         i_cmd,
    input  wire logic [1:0]        i_req_type,
    input  wire logic [DATA_W-1:0] i_push_value,
    output logic [1:0]             o_status,
    output logic [DATA_W-1:0]      o_pop_value,
    output logic                   o_now_empty
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    t_req              r_req;
    logic [DATA_W-1:0] r_value;
    logic [IDX_W-1:0]  r_top, n_top;
    logic [IDX_W-1:0]  r_bot, n_bot;
    logic              r_empty, n_empty;
    t_status           r_status, n_status;
    logic [DATA_W-1:0] r_pop_value;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    always_comb begin
        n_top    = r_top;
        n_bot    = r_bot;
        n_empty  = r_empty;
        n_status = ST_DONE;
        wr_en    = 1'b0;
        wr_addr  = '0;
        rd_en    = 1'b0;
        rd_addr  = r_top;
        unique case (r_req)
            REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
                if (r_empty) begin
                    // first item lands at slot 0 whichever end
                    n_top   = '0;
                    n_bot   = '0;
                    n_empty = 1'b0;
                    wr_en   = 1'b1;
                    wr_addr = '0;
                end else if (r_req == REQ_PUSH_FRONT) begin
                    if (r_top == LAST_IDX) begin
                        n_status = ST_FULL;
                    end else begin
                        n_top   = r_top + 1'b1;
                        wr_en   = 1'b1;
                        wr_addr = r_top + 1'b1;
                    end
                end else begin
                    // no wrap: rear is full at slot 0
                    if (r_bot == '0) begin
                        n_status = ST_FULL;
                    end else begin
                        n_bot   = r_bot - 1'b1;
                        wr_en   = 1'b1;
                        wr_addr = r_bot - 1'b1;
                    end
                end
            end
            REQ_POP_FRONT, REQ_POP_REAR: begin
                if (r_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = (r_req == REQ_POP_FRONT) ? r_top : r_bot;
                    if (r_top == r_bot) begin
                        n_empty = 1'b1;
                        n_top   = '0;
                        n_bot   = '0;
                    end else if (r_req == REQ_POP_FRONT) begin
                        n_top = r_top - 1'b1;
                    end else begin
                        n_bot = r_bot + 1'b1;
                    end
                end
            end
            default: n_status = ST_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top   <= '0;
            r_bot   <= '0;
            r_empty <= 1'b1;
        end else if (i_cmd.exec) begin
            r_top   <= n_top;
            r_bot   <= n_bot;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= t_req'(i_req_type);
            r_value <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_status    <= n_status;
            r_pop_value <= rd_en ? r_mem[rd_addr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[wr_addr] <= r_value;
        end
    end

    assign o_status    = r_status;
    assign o_pop_value = r_pop_value;
    assign o_now_empty = r_empty;

endmodule
`default_nettype wire

### hdl/linear_double_ended_queue_core.sv
// Top level of the linear double-ended queue core.
//
// Linear (non-wrapping) double-ended queue of eight 32-bit slots. Raise start
// with a request while busy is low; the item is taken at that edge and busy
// stays high through the execute and result cycles that follow. The result
// is on the ports in the second of those cycles, for exactly one cycle with
// o_valid high, and must be taken then: there is no back-pressure. Each request
// passes a capture cycle, an execute cycle that updates the indices and reads
// or writes the slot store, and the result cycle; a new one is taken only after
// it. A front push is refused at the last slot and a rear push at slot 0, even
// with room at the other end. o_now_empty reflects the deque after the request.
`default_nettype none
module linear_double_ended_queue_core
    import ldeq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        i_req_type,
    input  wire logic [DATA_W-1:0] i_push_value,
    output logic                   o_valid,
    output logic [1:0]             o_status,
    output logic [DATA_W-1:0]      o_pop_value,
    output logic                   o_now_empty
);

    t_ctrl_cmd cmd;

    ldeq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    ldeq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req_type   (i_req_type),
        .i_push_value (i_push_value),
        .o_status     (o_status),
        .o_pop_value  (o_pop_value),
        .o_now_empty  (o_now_empty)
    );

endmodule
`default_nettype wire
